// ===== design/rmt_pkg.sv =====
package rmt_pkg;

   // request position fields are fixed at six bits
   localparam int REQ_POS_W = 6;

   // unsigned Q2.30 relationship values
   localparam int FRAC_BITS = 30;
   localparam int VAL_W     = FRAC_BITS + 2;
   localparam int INB_W     = FRAC_BITS + 1;

   localparam logic [VAL_W-1:0] FIX_ONE =
      {{(VAL_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NO_PARENT = 2'd2,
      ST_NO_QUERY  = 2'd3
   } status_type;

   typedef logic [VAL_W-1:0] value_type;

endpackage

// ===== design/rmt_ram.sv =====
module rmt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/relationship_matrix_tabular.sv =====
// Numerator relationship matrix, tabular method, one animal per command.
//
// Command channel: drive req_* and raise start; the beat is taken at a
// rising edge where start is high and busy is low. req_opcode OP_ADD appends
// the next animal (optional sire/dam positions), OP_QUERY reads A for two
// stored positions. Result channel: rsp_valid strobes for exactly one cycle
// with rsp_status, rsp_animal_pos, rsp_inbreeding and rsp_relationship. The
// receiver cannot stall; the result register is simply overwritten by the
// next command, which may be started in the strobe cycle itself.
//
// Sequencing: an add builds the new row column by column, one column per
// animal already stored. Each column of the new row needs a sire read and
// a dam read on the single read port of the lower-triangle RAM; the write
// of the finished column overlaps the next read. Queries read a single
// entry; rejected commands answer straight from setup.
//
// Reset (synchronous, active high) empties the pedigree: the animal count
// and row base go to zero. The RAM itself is not cleared; only rows that
// were written are ever read.
module relationship_matrix_tabular
   import rmt_pkg::*;
#(
   parameter int MAX_ANIMALS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_opcode,
   input  logic                 req_sire_known,
   input  logic [REQ_POS_W-1:0] req_sire_pos,
   input  logic                 req_dam_known,
   input  logic [REQ_POS_W-1:0] req_dam_pos,
   input  logic [REQ_POS_W-1:0] req_query_first,
   input  logic [REQ_POS_W-1:0] req_query_second,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic [REQ_POS_W-1:0] rsp_animal_pos,
   output logic [INB_W-1:0]     rsp_inbreeding,
   output logic [VAL_W-1:0]     rsp_relationship
);

   localparam int DEPTH  = MAX_ANIMALS * (MAX_ANIMALS + 1) / 2;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(MAX_ANIMALS + 1);
   localparam int CMP_W  = (CNT_W > REQ_POS_W) ? CNT_W : REQ_POS_W;
   localparam int PROD_W = 2 * CNT_W + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SETUP,
      S_COL_S,
      S_COL_D,
      S_COL_LAST,
      S_F_WAIT,
      S_Q_RD,
      S_Q_WAIT
   } state_type;

   // start of row r in the packed lower triangle: r*(r+1)/2
   function automatic logic [ADDR_W-1:0] tri_base(input logic [CNT_W-1:0] r);
      logic [CNT_W:0]    r1;
      logic [PROD_W-1:0] prod;
      r1   = {1'b0, r} + 1'b1;
      prod = PROD_W'(r) * PROD_W'(r1);
      return ADDR_W'(prod >> 1);
   endfunction

   // control state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]  base_k_ff, base_k_in;   // row base of the next animal
   logic               pend_ff, pend_in;       // a column waits for its write
   logic               rsp_valid_ff, rsp_valid_in;

   // command and loop registers
   logic                 opcode_ff, opcode_in;
   logic                 sk_ff, sk_in;
   logic                 dk_ff, dk_in;
   logic [REQ_POS_W-1:0] sp_raw_ff, sp_raw_in;
   logic [REQ_POS_W-1:0] dp_raw_ff, dp_raw_in;
   logic [REQ_POS_W-1:0] q1_ff, q1_in;
   logic [REQ_POS_W-1:0] q2_ff, q2_in;
   logic [CNT_W-1:0]     s_ff, s_in;
   logic [CNT_W-1:0]     d_ff, d_in;
   logic [ADDR_W-1:0]    base_s_ff, base_s_in;
   logic [ADDR_W-1:0]    base_d_ff, base_d_in;
   logic [ADDR_W-1:0]    base_j_ff, base_j_in;
   logic [CNT_W-1:0]     j_ff, j_in;
   logic [CNT_W-1:0]     wcol_ff, wcol_in;
   value_type            sire_val_ff, sire_val_in;

   // result registers
   status_type           rsp_status_ff, rsp_status_in;
   logic [REQ_POS_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [INB_W-1:0]     rsp_inb_ff, rsp_inb_in;
   value_type            rsp_rel_ff, rsp_rel_in;

   // RAM port
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   value_type         ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   value_type         ram_rdata;

   // setup decode
   logic [CMP_W-1:0]     sp_ext, dp_ext, q1_ext, q2_ext, cnt_ext;
   logic [REQ_POS_W-1:0] q_hi, q_lo;
   logic [CMP_W-1:0]     q_hi_ext, q_lo_ext;
   logic [CMP_W-1:0]     s_sel_ext, d_sel_ext;
   logic                 is_full, no_parent, q_absent;

   // datapath
   logic [VAL_W:0]    col_sum;
   value_type         dam_val;
   value_type         f_val;
   value_type         diag_val;
   logic [CNT_W:0]    j_next;

   rmt_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      sp_ext    = CMP_W'(sp_raw_ff);
      dp_ext    = CMP_W'(dp_raw_ff);
      q1_ext    = CMP_W'(q1_ff);
      q2_ext    = CMP_W'(q2_ff);
      cnt_ext   = CMP_W'(count_ff);
      q_hi      = (q1_ff > q2_ff) ? q1_ff : q2_ff;
      q_lo      = (q1_ff > q2_ff) ? q2_ff : q1_ff;
      q_hi_ext  = CMP_W'(q_hi);
      q_lo_ext  = CMP_W'(q_lo);
      is_full   = (count_ff == CNT_W'(MAX_ANIMALS));
      no_parent = (sk_ff && (sp_ext >= cnt_ext)) || (dk_ff && (dp_ext >= cnt_ext));
      q_absent  = (q1_ext >= cnt_ext) || (q2_ext >= cnt_ext);
      s_sel_ext = (opcode_ff == OP_ADD) ? sp_ext : q_hi_ext;
      d_sel_ext = (opcode_ff == OP_ADD) ? dp_ext : q_lo_ext;

      // dam data arrives in the cycle after its read; unknown parent reads as zero
      dam_val  = dk_ff ? ram_rdata : '0;
      col_sum  = {1'b0, sire_val_ff} + {1'b0, dam_val};
      f_val    = (sk_ff && dk_ff) ? (ram_rdata >> 1) : '0;
      diag_val = FIX_ONE + f_val;
      j_next   = {1'b0, j_ff} + 1'b1;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      base_k_in     = base_k_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      opcode_in     = opcode_ff;
      sk_in         = sk_ff;
      dk_in         = dk_ff;
      sp_raw_in     = sp_raw_ff;
      dp_raw_in     = dp_raw_ff;
      q1_in         = q1_ff;
      q2_in         = q2_ff;
      s_in          = s_ff;
      d_in          = d_ff;
      base_s_in     = base_s_ff;
      base_d_in     = base_d_ff;
      base_j_in     = base_j_ff;
      j_in          = j_ff;
      wcol_in       = wcol_ff;
      sire_val_in   = sire_val_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_inb_in    = rsp_inb_ff;
      rsp_rel_in    = rsp_rel_ff;

      ram_we    = 1'b0;
      ram_waddr = base_k_ff + ADDR_W'(wcol_ff);
      ram_wdata = col_sum[VAL_W:1];
      ram_re    = 1'b0;
      ram_raddr = base_s_ff + ADDR_W'(d_ff);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               opcode_in = req_opcode;
               sk_in     = req_sire_known;
               dk_in     = req_dam_known;
               sp_raw_in = req_sire_pos;
               dp_raw_in = req_dam_pos;
               q1_in     = req_query_first;
               q2_in     = req_query_second;
               state_in  = S_SETUP;
            end
         end

         S_SETUP: begin
            s_in      = s_sel_ext[CNT_W-1:0];
            d_in      = d_sel_ext[CNT_W-1:0];
            base_s_in = tri_base(s_sel_ext[CNT_W-1:0]);
            base_d_in = tri_base(d_sel_ext[CNT_W-1:0]);
            j_in      = '0;
            base_j_in = '0;
            pend_in   = 1'b0;
            rsp_pos_in = '0;
            rsp_inb_in = '0;
            rsp_rel_in = '0;
            if (opcode_ff == OP_ADD) begin
               if (is_full) begin
                  rsp_status_in = ST_FULL;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end else if (no_parent) begin
                  rsp_status_in = ST_NO_PARENT;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end else if (count_ff == '0) begin
                  state_in = S_COL_LAST;
               end else begin
                  state_in = S_COL_S;
               end
            end else begin
               if (q_absent) begin
                  rsp_status_in = ST_NO_QUERY;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_Q_RD;
               end
            end
         end

         // read sire entry of column j, retire the previous column
         S_COL_S: begin
            ram_re    = sk_ff;
            ram_raddr = (j_ff <= s_ff) ? (base_s_ff + ADDR_W'(j_ff))
                                       : (base_j_ff + ADDR_W'(s_ff));
            ram_we    = pend_ff;
            state_in  = S_COL_D;
         end

         // read dam entry of column j, hold the sire value
         S_COL_D: begin
            ram_re      = dk_ff;
            ram_raddr   = (j_ff <= d_ff) ? (base_d_ff + ADDR_W'(j_ff))
                                         : (base_j_ff + ADDR_W'(d_ff));
            sire_val_in = sk_ff ? ram_rdata : '0;
            wcol_in     = j_ff;
            pend_in     = 1'b1;
            j_in        = j_next[CNT_W-1:0];
            base_j_in   = base_j_ff + ADDR_W'(j_next);
            if (j_next == (CNT_W+1)'(count_ff)) begin
               state_in = S_COL_LAST;
            end else begin
               state_in = S_COL_S;
            end
         end

         // retire last column, fetch A[s][d]
         S_COL_LAST: begin
            ram_we    = pend_ff;
            ram_re    = sk_ff && dk_ff;
            ram_raddr = (s_ff >= d_ff) ? (base_s_ff + ADDR_W'(d_ff))
                                       : (base_d_ff + ADDR_W'(s_ff));
            pend_in   = 1'b0;
            state_in  = S_F_WAIT;
         end

         S_F_WAIT: begin
            ram_we        = 1'b1;
            ram_waddr     = base_k_ff + ADDR_W'(count_ff);
            ram_wdata     = diag_val;
            count_in      = count_ff + 1'b1;
            base_k_in     = base_k_ff + ADDR_W'(count_ff) + 1'b1;
            rsp_status_in = ST_OK;
            rsp_pos_in    = REQ_POS_W'(count_ff);
            rsp_inb_in    = f_val[INB_W-1:0];
            rsp_rel_in    = diag_val;
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end

         S_Q_RD: begin
            ram_re    = 1'b1;
            ram_raddr = base_s_ff + ADDR_W'(d_ff);
            state_in  = S_Q_WAIT;
         end

         S_Q_WAIT: begin
            rsp_status_in = ST_OK;
            rsp_pos_in    = '0;
            rsp_inb_in    = '0;
            rsp_rel_in    = ram_rdata;
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         base_k_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         base_k_ff    <= base_k_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      opcode_ff     <= opcode_in;
      sk_ff         <= sk_in;
      dk_ff         <= dk_in;
      sp_raw_ff     <= sp_raw_in;
      dp_raw_ff     <= dp_raw_in;
      q1_ff         <= q1_in;
      q2_ff         <= q2_in;
      s_ff          <= s_in;
      d_ff          <= d_in;
      base_s_ff     <= base_s_in;
      base_d_ff     <= base_d_in;
      base_j_ff     <= base_j_in;
      j_ff          <= j_in;
      wcol_ff       <= wcol_in;
      sire_val_ff   <= sire_val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_inb_ff    <= rsp_inb_in;
      rsp_rel_ff    <= rsp_rel_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_animal_pos   = rsp_pos_ff;
   assign rsp_inbreeding   = rsp_inb_ff;
   assign rsp_relationship = rsp_rel_ff;

`ifndef NO_ASSERTIONS
   // a result beat only ever closes out a command in flight
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a command in flight");

   // writes stay inside the packed triangle
   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (ram_waddr < ADDR_W'(DEPTH)))
      else $error("store write beyond triangle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ANIMALS))
      else $error("animal count above capacity");

   // the pedigree grows only together with a successful add result
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> (rsp_valid && (rsp_status == ST_OK)))
      else $error("animal count moved without an ok result");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rmt_pkg::*;

   // pedigree size of the instance; positions are six bits wide
   localparam int HERD_MAX     = 64;
   // directed rows walked before the random beats; the rest need a full herd
   localparam int HEAD_ROWS    = 22;
   localparam int PLAN_ROWS    = 25;
   localparam int RAND_PER_PH  = 270;
   // drain time at the end, past the longest add
   localparam int DRAIN_CYCLES = 2 * HERD_MAX + 20;

   typedef struct packed {
      logic                 opcode;
      logic                 sire_known;
      logic [REQ_POS_W-1:0] sire_idx;
      logic                 dam_known;
      logic [REQ_POS_W-1:0] dam_pos;
      logic [REQ_POS_W-1:0] first;
      logic [REQ_POS_W-1:0] second;
   } beat_type;

   localparam int BEAT_W = $bits(beat_type);

   typedef struct packed {
      status_type           status;
      logic [REQ_POS_W-1:0] pos;
      logic [INB_W-1:0]     inb;
      value_type            rel;
   } result_type;

   // one directed row: the command, and a hand-typed answer where pinned is set
   typedef struct packed {
      beat_type   cmd;
      logic       pinned;
      result_type want;
   } plan_row_type;

   localparam result_type RES_NONE      = '{ST_OK, '0, '0, '0};
   localparam result_type RES_FULL      = '{ST_FULL, '0, '0, '0};
   localparam result_type RES_NO_PARENT = '{ST_NO_PARENT, '0, '0, '0};
   localparam result_type RES_NO_QUERY  = '{ST_NO_QUERY, '0, '0, '0};

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_opcode;
   logic                 req_sire_known;
   logic [REQ_POS_W-1:0] req_sire_pos;
   logic                 req_dam_known;
   logic [REQ_POS_W-1:0] req_dam_pos;
   logic [REQ_POS_W-1:0] req_query_first;
   logic [REQ_POS_W-1:0] req_query_second;
   logic                 rsp_valid;
   logic [1:0]           rsp_status;
   logic [REQ_POS_W-1:0] rsp_animal_pos;
   logic [INB_W-1:0]     rsp_inbreeding;
   logic [VAL_W-1:0]     rsp_relationship;

   // shadow pedigree: full symmetric A matrix and the number of animals held
   value_type kinship [HERD_MAX][HERD_MAX];
   int        herd_size = 0;

   // results still owed by the block, oldest first
   result_type owed_results [$];

   // typed answer for the beat on the bus, set together with the beat
   logic       pin_valid  = 1'b0;
   result_type pin_result = RES_NONE;

   plan_row_type plan [PLAN_ROWS];
   int         gap_pct = 0;
   int         faults = 0;
   int         beats_taken = 0;
   int         query_tally = 0;
   int         status_tally [4] = '{0, 0, 0, 0};
   beat_type   taken;
   result_type due_rsp;

   relationship_matrix_tabular #(
      .MAX_ANIMALS(HERD_MAX)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_sire_known  (req_sire_known),
      .req_sire_pos    (req_sire_pos),
      .req_dam_known   (req_dam_known),
      .req_dam_pos     (req_dam_pos),
      .req_query_first (req_query_first),
      .req_query_second(req_query_second),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_animal_pos  (rsp_animal_pos),
      .rsp_inbreeding  (rsp_inbreeding),
      .rsp_relationship(rsp_relationship)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // tabular method, one beat: add appends row k, query reads A[first][second]
   function automatic result_type breed_step(beat_type b);
      result_type     r;
      logic [VAL_W:0] sum;
      value_type      sire_v;
      value_type      dam_v;
      value_type      f;
      int             k;
      int             j;
      r = RES_NONE;
      k = herd_size;
      if (b.opcode == OP_ADD) begin
         if (k >= HERD_MAX) begin
            r.status = ST_FULL;   // full wins over a missing parent
         end else if ((b.sire_known && b.sire_idx >= k) ||
                      (b.dam_known && b.dam_pos >= k)) begin
            r.status = ST_NO_PARENT;
         end else begin
            // unknown parent reads as an all-zero row
            for (j = 0; j < k; j++) begin
               sire_v = b.sire_known ? kinship[b.sire_idx][j] : '0;
               dam_v  = b.dam_known ? kinship[b.dam_pos][j] : '0;
               sum    = {1'b0, sire_v} + {1'b0, dam_v};
               kinship[k][j] = sum[VAL_W:1];
               kinship[j][k] = sum[VAL_W:1];
            end
            // F = A[s][d]/2, truncated; same sire and dam picks the diagonal
            f = (b.sire_known && b.dam_known) ? kinship[b.sire_idx][b.dam_pos] >> 1 : '0;
            kinship[k][k] = FIX_ONE + f;
            herd_size     = k + 1;
            r.pos = REQ_POS_W'(k);
            r.inb = f[INB_W-1:0];
            r.rel = FIX_ONE + f;
         end
      end else if (b.first >= k || b.second >= k) begin
         r.status = ST_NO_QUERY;
      end else begin
         r.rel = kinship[b.first][b.second];
      end
      return r;
   endfunction

   // random beat; mostly well-formed so the pedigree grows deep and inbred
   function automatic beat_type draw_beat();
      beat_type b;
      b = BEAT_W'($urandom);   // unused fields stay random junk
      b.opcode = ($urandom_range(99) < 15) ? OP_ADD : OP_QUERY;
      if (b.opcode == OP_ADD && herd_size < HERD_MAX) begin
         if (herd_size == 0) begin
            b.sire_known = 1'b0;
            b.dam_known  = 1'b0;
         end else begin
            b.sire_known = ($urandom_range(4) != 0);
            b.dam_known  = ($urandom_range(4) != 0);
            b.sire_idx   = REQ_POS_W'($urandom_range(herd_size - 1));
            b.dam_pos    = REQ_POS_W'($urandom_range(herd_size - 1));
            if ($urandom_range(9) == 0)
               b.dam_pos = b.sire_idx;
         end
         // broken add: a known parent that is not stored yet
         if ($urandom_range(99) < 12) begin
            if ($urandom_range(1) == 0) begin
               b.sire_known = 1'b1;
               b.sire_idx   = REQ_POS_W'($urandom_range(HERD_MAX - 1, herd_size));
            end else begin
               b.dam_known = 1'b1;
               b.dam_pos   = REQ_POS_W'($urandom_range(HERD_MAX - 1, herd_size));
            end
         end
      end else if (b.opcode == OP_QUERY && herd_size > 0 && $urandom_range(9) != 0) begin
         b.first  = REQ_POS_W'($urandom_range(herd_size - 1));
         b.second = REQ_POS_W'($urandom_range(herd_size - 1));
      end
      return b;
   endfunction

   // caller sits at a falling edge; returns at the falling edge after the take
   task automatic drive_beat(beat_type b, logic pinned, result_type want);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      {req_opcode, req_sire_known, req_sire_pos, req_dam_known, req_dam_pos,
       req_query_first, req_query_second} <= b;
      start <= 1'b1;
      pin_valid  = pinned;
      pin_result = want;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic check_field(string tag, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, tag, want, got);
         faults++;
      end
   endtask

   // scoreboard: results are checked before the new beat is predicted, since a
   // command may be taken in the very cycle the previous result strobes
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (owed_results.size() == 0) begin
               $display("%0t ns: result beat with nothing expected, status %0d",
                        $time, rsp_status);
               faults++;
            end else begin
               due_rsp = owed_results.pop_front();
               check_field("status", due_rsp.status, rsp_status);
               check_field("animal_pos", due_rsp.pos, rsp_animal_pos);
               check_field("inbreeding", due_rsp.inb, rsp_inbreeding);
               check_field("relationship", due_rsp.rel, rsp_relationship);
            end
         end
         if (start && !busy) begin
            taken = {req_opcode, req_sire_known, req_sire_pos, req_dam_known, req_dam_pos,
                     req_query_first, req_query_second};
            due_rsp = breed_step(taken);
            if (pin_valid)
               due_rsp = pin_result;
            owed_results.push_back(due_rsp);
            beats_taken++;
            status_tally[due_rsp.status]++;
            if (taken.opcode == OP_QUERY && due_rsp.status == ST_OK)
               query_tally++;
         end
      end
   end

   initial begin
      int       i;
      beat_type nb;

      reset            = 1'b1;
      start            = 1'b0;
      req_opcode       = OP_ADD;
      req_sire_known   = 1'b0;
      req_sire_pos     = '0;
      req_dam_known    = 1'b0;
      req_dam_pos      = '0;
      req_query_first  = '0;
      req_query_second = '0;

      // cmd fields: opcode, sire known/pos, dam known/pos, query first/second
      // empty pedigree: nothing to query, no parent present
      plan[0]  = '{'{OP_QUERY, 1'b0, 6'd0, 1'b0, 6'd0, 6'd0, 6'd0}, 1'b1, RES_NO_QUERY};
      plan[1]  = '{'{OP_ADD, 1'b1, 6'd0, 1'b0, 6'd0, 6'd0, 6'd0}, 1'b1, RES_NO_PARENT};
      plan[2]  = '{'{OP_ADD, 1'b0, 6'd0, 1'b1, 6'd0, 6'd0, 6'd0}, 1'b1, RES_NO_PARENT};
      // founders; positions of unknown parents are ignored
      plan[3]  = '{'{OP_ADD, 1'b0, 6'd63, 1'b0, 6'd63, 6'd63, 6'd63}, 1'b1,
                   '{ST_OK, 6'd0, 31'd0, FIX_ONE}};
      plan[4]  = '{'{OP_ADD, 1'b0, 6'd0, 1'b0, 6'd0, 6'd0, 6'd0}, 1'b1,
                   '{ST_OK, 6'd1, 31'd0, FIX_ONE}};
      plan[5]  = '{'{OP_QUERY, 1'b0, 6'd0, 1'b0, 6'd0, 6'd0, 6'd0}, 1'b1,
                   '{ST_OK, 6'd0, 31'd0, FIX_ONE}};
      plan[6]  = '{'{OP_QUERY, 1'b0, 6'd0, 1'b0, 6'd0, 6'd1, 6'd0}, 1'b1, RES_NONE};
      // unrelated parents: not inbred
      plan[7]  = '{'{OP_ADD, 1'b1, 6'd0, 1'b1, 6'd1, 6'd0, 6'd0}, 1'b1,
                   '{ST_OK, 6'd2, 31'd0, FIX_ONE}};
      // same sire and dam, then one parent unknown
      plan[8]  = '{'{OP_ADD, 1'b1, 6'd2, 1'b1, 6'd2, 6'd0, 6'd0}, 1'b0, RES_NONE};
      plan[9]  = '{'{OP_ADD, 1'b1, 6'd3, 1'b0, 6'd63, 6'd0, 6'd0}, 1'b0, RES_NONE};
      // parent not stored yet: top position, and a dam just past the herd
      plan[10] = '{'{OP_ADD, 1'b1, 6'd63, 1'b0, 6'd0, 6'd0, 6'd0}, 1'b1, RES_NO_PARENT};
      plan[11] = '{'{OP_ADD, 1'b1, 6'd3, 1'b1, 6'd5, 6'd0, 6'd0}, 1'b1, RES_NO_PARENT};
      plan[12] = '{'{OP_ADD, 1'b0, 6'd0, 1'b1, 6'd4, 6'd0, 6'd0}, 1'b0, RES_NONE};
      plan[13] = '{'{OP_ADD, 1'b1, 6'd4, 1'b1, 6'd3, 6'd0, 6'd0}, 1'b0, RES_NONE};
      plan[14] = '{'{OP_ADD, 1'b1, 6'd6, 1'b1, 6'd5, 6'd0, 6'd0}, 1'b0, RES_NONE};
      // query order must not matter
      plan[15] = '{'{OP_QUERY, 1'b0, 6'd0, 1'b0, 6'd0, 6'd7, 6'd3}, 1'b0, RES_NONE};
      plan[16] = '{'{OP_QUERY, 1'b0, 6'd0, 1'b0, 6'd0, 6'd3, 6'd7}, 1'b0, RES_NONE};
      plan[17] = '{'{OP_QUERY, 1'b0, 6'd0, 1'b0, 6'd0, 6'd63, 6'd0}, 1'b1, RES_NO_QUERY};
      plan[18] = '{'{OP_QUERY, 1'b0, 6'd0, 1'b0, 6'd0, 6'd0, 6'd63}, 1'b1, RES_NO_QUERY};
      plan[19] = '{'{OP_QUERY, 1'b0, 6'd0, 1'b0, 6'd0, 6'd7, 6'd7}, 1'b0, RES_NONE};
      // queries carrying junk add fields; first one just past the herd
      plan[20] = '{'{OP_QUERY, 1'b1, 6'd63, 1'b1, 6'd63, 6'd8, 6'd2}, 1'b1, RES_NO_QUERY};
      plan[21] = '{'{OP_QUERY, 1'b1, 6'd63, 1'b1, 6'd63, 6'd5, 6'd5}, 1'b0, RES_NONE};
      // full herd: full is reported even with both parents named
      plan[22] = '{'{OP_ADD, 1'b0, 6'd0, 1'b0, 6'd0, 6'd0, 6'd0}, 1'b1, RES_FULL};
      plan[23] = '{'{OP_ADD, 1'b1, 6'd63, 1'b1, 6'd63, 6'd0, 6'd0}, 1'b1, RES_FULL};
      plan[24] = '{'{OP_QUERY, 1'b0, 6'd0, 1'b0, 6'd0, 6'd63, 6'd0}, 1'b0, RES_NONE};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // phase 1: sender pauses before about a quarter of the beats
      gap_pct = 26;
      for (i = 0; i < HEAD_ROWS; i++)
         drive_beat(plan[i].cmd, plan[i].pinned, plan[i].want);
      for (i = 0; i < RAND_PER_PH; i++)
         drive_beat(draw_beat(), 1'b0, RES_NONE);

      // phase 2: sender pauses before more than half of the beats; herd fills up here
      gap_pct = 55;
      for (i = 0; i < RAND_PER_PH; i++)
         drive_beat(draw_beat(), 1'b0, RES_NONE);
      while (herd_size < HERD_MAX) begin
         nb = draw_beat();
         if (nb.opcode == OP_ADD)
            drive_beat(nb, 1'b0, RES_NONE);
      end
      for (i = HEAD_ROWS; i < PLAN_ROWS; i++)
         drive_beat(plan[i].cmd, plan[i].pinned, plan[i].want);

      // phase 3: back to back
      gap_pct = 0;
      for (i = 0; i < RAND_PER_PH; i++)
         drive_beat(draw_beat(), 1'b0, RES_NONE);
      start <= 1'b0;

      while (owed_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Took %0d command beats: %0d animals added, %0d queries answered.",
               beats_taken, status_tally[ST_OK] - query_tally, query_tally);
      $display("Rejected: %0d on full herd, %0d missing parent, %0d absent query position.",
               status_tally[ST_FULL], status_tally[ST_NO_PARENT], status_tally[ST_NO_QUERY]);
      if (faults == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #10ms;
      $display("FAIL");
      $finish;
   end

endmodule
